// ===== rtl/core/irpft_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpft_pkg
// shared types and constants of the ir parity frame transmitter
// ----------------------------------------------------------------------------
package irpft_pkg;

  // frame sequencer phases
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_START  = 3'd1,
    PH_DATA   = 3'd2,
    PH_PARITY = 3'd3,
    PH_STOP   = 3'd4,
    PH_HOLD   = 3'd5
  } phase_e;

  // configuration register indexes
  localparam int unsigned CfgAddrW = 3;
  localparam logic [CfgAddrW-1:0] CFG_BIT_TICKS       = 3'd0;
  localparam logic [CfgAddrW-1:0] CFG_CARRIER_TOP     = 3'd1;
  localparam logic [CfgAddrW-1:0] CFG_CARRIER_COMPARE = 3'd2;
  localparam logic [CfgAddrW-1:0] CFG_LSB_FIRST       = 3'd3;
  localparam logic [CfgAddrW-1:0] CFG_FRAME_CODE      = 3'd4;
  localparam logic [CfgAddrW-1:0] CFG_HOLDOFF_TICKS   = 3'd5;

  // field widths
  localparam int unsigned TickW    = 16;
  localparam int unsigned CarrierW = 16;
  localparam int unsigned CodeW    = 8;
  localparam int unsigned HoldW    = 22;
  localparam int unsigned CfgDataW = 22;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 8;

  // reset values of the configuration registers
  localparam logic [TickW-1:0]    BIT_TICKS_RST       = 16'd16000;
  localparam logic [CarrierW-1:0] CARRIER_TOP_RST     = 16'd421;
  localparam logic [CarrierW-1:0] CARRIER_COMPARE_RST = 16'd210;
  localparam logic [CodeW-1:0]    FRAME_CODE_RST      = 8'd240;
  localparam logic [HoldW-1:0]    HOLDOFF_TICKS_RST   = 22'd1600000;

endpackage

// ===== rtl/core/ir_parity_frame_transmitter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_parity_frame_transmitter_core
// pwm carrier, framed byte with even parity, indicator and holdoff per tick
// ----------------------------------------------------------------------------
// result: the result word of an accepted input word is registered and presented in the next cycle
// throughput: one word per cycle while m_axis_tready does not hold the result stream, set by the state update
//   (carrier counter, symbol tick compare, holdoff decrement)
// reset: rst_ni clears the transmitter state and the result valid flag to idle (the result data is not
//   reset) and loads the register defaults; no clearing pass, words are accepted as soon as reset is released
module ir_parity_frame_transmitter_core #(
  parameter int unsigned DATA_BITS = 8  // 1..8, low bits of frame_code sent
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [irpft_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [irpft_pkg::CfgDataW-1:0] cfg_wdata_i,
  // input stream, one word per tick
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [irpft_pkg::InDataW-1:0]  s_axis_tdata,  // [0] trigger_held
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [irpft_pkg::OutDataW-1:0] m_axis_tdata   // [0] ir_drive [1] led_on [2] busy_res
);

  localparam int unsigned IdxW = (DATA_BITS > 1) ? $clog2(DATA_BITS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(DATA_BITS - 1);

  // configuration registers
  logic [irpft_pkg::TickW-1:0]    bit_ticks_q;
  logic [irpft_pkg::CarrierW-1:0] carrier_top_q;
  logic [irpft_pkg::CarrierW-1:0] carrier_cmp_q;
  logic                           lsb_first_q;
  logic [irpft_pkg::CodeW-1:0]    frame_code_q;
  logic [irpft_pkg::HoldW-1:0]    holdoff_ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_ticks_q     <= irpft_pkg::BIT_TICKS_RST;
      carrier_top_q   <= irpft_pkg::CARRIER_TOP_RST;
      carrier_cmp_q   <= irpft_pkg::CARRIER_COMPARE_RST;
      lsb_first_q     <= 1'b0;
      frame_code_q    <= irpft_pkg::FRAME_CODE_RST;
      holdoff_ticks_q <= irpft_pkg::HOLDOFF_TICKS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        irpft_pkg::CFG_BIT_TICKS:       bit_ticks_q     <= cfg_wdata_i[15:0];
        irpft_pkg::CFG_CARRIER_TOP:     carrier_top_q   <= cfg_wdata_i[15:0];
        irpft_pkg::CFG_CARRIER_COMPARE: carrier_cmp_q   <= cfg_wdata_i[15:0];
        irpft_pkg::CFG_LSB_FIRST:       lsb_first_q     <= cfg_wdata_i[0];
        irpft_pkg::CFG_FRAME_CODE:      frame_code_q    <= cfg_wdata_i[7:0];
        irpft_pkg::CFG_HOLDOFF_TICKS:   holdoff_ticks_q <= cfg_wdata_i[21:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // transmitter state
  logic [irpft_pkg::CarrierW-1:0] carrier_cnt_q, carrier_cnt_d;
  irpft_pkg::phase_e              phase_q, phase_d;
  logic [IdxW-1:0]                bit_idx_q, bit_idx_d;
  logic [DATA_BITS-1:0]           shift_q, shift_d;
  logic                           parity_q, parity_d;
  logic [irpft_pkg::TickW-1:0]    tick_q, tick_d;
  logic [irpft_pkg::HoldW-1:0]    hold_q, hold_d;
  logic                           led_q, led_d;

  // output register
  logic                           out_valid_q;
  logic [irpft_pkg::OutDataW-1:0] out_data_q;
  logic [irpft_pkg::OutDataW-1:0] result;

  logic accept;
  logic trig;
  logic carrier;
  logic symbol;
  logic busy;
  logic data_bit;
  logic sym_done;
  logic [irpft_pkg::TickW:0] sym_len;
  logic [irpft_pkg::TickW:0] tick_inc;
  irpft_pkg::phase_e ph_eff;

  // a new word enters whenever the result register is free or draining
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign trig          = s_axis_tdata[0];

  always_comb begin
    carrier = (carrier_cnt_q < carrier_cmp_q);
    carrier_cnt_d = (carrier_cnt_q >= carrier_top_q) ? '0 : carrier_cnt_q + 1'b1;

    phase_d  = phase_q;
    bit_idx_d = bit_idx_q;
    shift_d  = shift_q;
    parity_d = parity_q;
    tick_d   = tick_q;
    hold_d   = hold_q;
    led_d    = led_q;
    symbol   = 1'b0;
    busy     = 1'b0;

    // idle: a held trigger starts the frame on this very tick
    ph_eff = phase_q;
    if (phase_q == irpft_pkg::PH_IDLE) begin
      if (trig) begin
        ph_eff    = irpft_pkg::PH_START;
        tick_d    = '0;
        bit_idx_d = '0;
        parity_d  = 1'b0;
        shift_d   = frame_code_q[DATA_BITS-1:0];
      end else begin
        led_d = 1'b0;
      end
    end
    phase_d = ph_eff;

    data_bit = lsb_first_q ? shift_d[0] : shift_d[DATA_BITS-1];

    // symbol length: half bit for the start mark, zero length counts as one
    sym_len = (ph_eff == irpft_pkg::PH_START) ? {2'b00, bit_ticks_q[15:1]}
                                              : {1'b0, bit_ticks_q};
    if (sym_len == '0) sym_len = {{irpft_pkg::TickW{1'b0}}, 1'b1};
    tick_inc = {1'b0, tick_d} + 1'b1;
    sym_done = (tick_inc >= sym_len);

    unique case (ph_eff)
      irpft_pkg::PH_START: begin
        busy   = 1'b1;
        symbol = 1'b1;
        if (sym_done) phase_d = irpft_pkg::PH_DATA;
      end
      irpft_pkg::PH_DATA: begin
        busy   = 1'b1;
        symbol = data_bit;
        if (sym_done) begin
          parity_d = parity_d ^ data_bit;
          shift_d  = lsb_first_q ? (shift_d >> 1) : (shift_d << 1);
          if (bit_idx_d == LastIdx) begin
            bit_idx_d = '0;
            phase_d   = irpft_pkg::PH_PARITY;
          end else begin
            bit_idx_d = bit_idx_d + 1'b1;
          end
        end
      end
      irpft_pkg::PH_PARITY: begin
        busy   = 1'b1;
        symbol = parity_d;
        if (sym_done) phase_d = irpft_pkg::PH_STOP;
      end
      irpft_pkg::PH_STOP: begin
        busy   = 1'b1;
        symbol = 1'b1;
        if (sym_done) begin
          led_d   = 1'b1;
          hold_d  = holdoff_ticks_q;
          phase_d = (holdoff_ticks_q == '0) ? irpft_pkg::PH_IDLE : irpft_pkg::PH_HOLD;
        end
      end
      irpft_pkg::PH_HOLD: begin
        busy = 1'b1;
        if (hold_q <= irpft_pkg::HoldW'(1)) begin
          hold_d  = '0;
          phase_d = irpft_pkg::PH_IDLE;
        end else begin
          hold_d = hold_q - 1'b1;
        end
      end
      irpft_pkg::PH_IDLE: ;
      default: phase_d = irpft_pkg::PH_IDLE;
    endcase

    // symbol counter only moves in the timed phases
    if (ph_eff == irpft_pkg::PH_START || ph_eff == irpft_pkg::PH_DATA ||
        ph_eff == irpft_pkg::PH_PARITY || ph_eff == irpft_pkg::PH_STOP) begin
      tick_d = sym_done ? '0 : tick_inc[irpft_pkg::TickW-1:0];
    end

    result = {5'b00000, busy, led_d, symbol & carrier};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carrier_cnt_q <= '0;
      phase_q       <= irpft_pkg::PH_IDLE;
      bit_idx_q     <= '0;
      shift_q       <= '0;
      parity_q      <= 1'b0;
      tick_q        <= '0;
      hold_q        <= '0;
      led_q         <= 1'b0;
    end else if (accept) begin
      carrier_cnt_q <= carrier_cnt_d;
      phase_q       <= phase_d;
      bit_idx_q     <= bit_idx_d;
      shift_q       <= shift_d;
      parity_q      <= parity_d;
      tick_q        <= tick_d;
      hold_q        <= hold_d;
      led_q         <= led_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef ASSERT_OFF
  // the emitter never lights outside a frame
  a_drive_needs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[2] |-> !m_axis_tdata[0])
    else $error("ir drive active while not busy");

  // holdoff phase always has ticks left to count
  a_hold_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == irpft_pkg::PH_HOLD |-> hold_q != '0)
    else $error("holdoff phase with zero count");

  // bit index only advances inside the data phase
  a_idx_in_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != irpft_pkg::PH_DATA |-> bit_idx_q == '0)
    else $error("bit index nonzero outside data phase");

  // a trigger seen while idle yields a busy result on the next cycle
  a_trigger_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && trig && phase_q == irpft_pkg::PH_IDLE |=> m_axis_tvalid && m_axis_tdata[2])
    else $error("trigger did not start a frame");
`endif

endmodule
